// ===== rtl/qrv_pkg.sv =====
// ----------------------------------------------------------------------------
// qrv_pkg
// Widths, pipeline control type and coefficient type shared by the
// quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qrv_pkg;

  localparam int QUAT_W    = 16;              // Q2.14 quaternion component
  localparam int VEC_W     = 32;              // Q16.16 vector component
  localparam int PROD_W    = 2 * QUAT_W;      // Q4.28 quadratic term
  localparam int COEF_W    = PROD_W + 2;      // matrix coefficient, full range
  localparam int HALF_W    = VEC_W / 2;       // vector split into halves
  localparam int PH_W      = COEF_W + HALF_W;       // coef * signed high half
  localparam int PL_W      = COEF_W + HALF_W + 1;   // coef * unsigned low half
  localparam int HI_W      = PH_W + 2;        // sum of three high products
  localparam int LO_W      = PL_W + 2;        // sum of three low products
  localparam int SUM_W     = HI_W + HALF_W + 2;     // exact row sum
  localparam int FRAC_DROP = 28;              // Q.44 down to Q16.16
  localparam int RES_W     = SUM_W - FRAC_DROP;

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // Load strobes for the five pipeline stages.
  typedef struct packed {
    logic prod;
    logic coef;
    logic mul;
    logic acc;
    logic fin;
  } pipe_ctl_t;

endpackage

// ===== rtl/qrv_item_if.sv =====
// ----------------------------------------------------------------------------
// qrv_item_if
// Input channel: one quaternion and one vector per word.
// ----------------------------------------------------------------------------
interface qrv_item_if import qrv_pkg::*; ();

  logic  valid;
  logic  ready;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  quat_t quat_w;
  vec_t  vec_x;
  vec_t  vec_y;
  vec_t  vec_z;

  modport source (
    output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
    input  ready
  );

  modport sink (
    input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
    output ready
  );

endinterface

// ===== rtl/qrv_result_if.sv =====
// ----------------------------------------------------------------------------
// qrv_result_if
// Output channel: rotated vector and saturation flag per word.
// ----------------------------------------------------------------------------
interface qrv_result_if import qrv_pkg::*; ();

  logic valid;
  logic ready;
  vec_t rot_x;
  vec_t rot_y;
  vec_t rot_z;
  logic clipped;

  modport source (
    output valid, rot_x, rot_y, rot_z, clipped,
    input  ready
  );

  modport sink (
    input  valid, rot_x, rot_y, rot_z, clipped,
    output ready
  );

endinterface

// ===== rtl/quat_rotate_vector_unit.sv =====
// ----------------------------------------------------------------------------
// quat_rotate_vector_unit
// Rotates a Q16.16 vector by a Q2.14 quaternion, v' = q v conj(q), with one
// rounding and saturation at the end.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while result.ready holds; each of the five
// register stages has its own valid bit and loads whenever the stage after
// it is empty or moving.
// Reset clears the valid bits only; the data registers hold no reset value.
// ----------------------------------------------------------------------------
module quat_rotate_vector_unit import qrv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qrv_item_if.sink    item,
  qrv_result_if.source result
);

  localparam int STAGES = 5;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] valid_next;
  logic [STAGES-1:0] ready;
  logic [STAGES-1:0] load;
  logic [STAGES-1:0] upstream;
  pipe_ctl_t         ctl;

  vec_t  vec_s1 [0:2];
  vec_t  vec_s2 [0:2];
  coef_t coef   [0:2][0:2];
  vec_t  rot    [0:2];
  logic  clip   [0:2];

  always_comb begin
    upstream = {valid[STAGES-2:0], item.valid};
    ready[STAGES-1] = !valid[STAGES-1] || result.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
    load = ready & upstream;
    for (int k = 0; k < STAGES; k++) begin
      valid_next[k] = ready[k] ? upstream[k] : valid[k];
    end
    ctl.prod = load[0];
    ctl.coef = load[1];
    ctl.mul  = load[2];
    ctl.acc  = load[3];
    ctl.fin  = load[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  // The vector rides along with the coefficient stages.
  always_ff @(posedge clk) begin
    if (ctl.prod) begin
      vec_s1[0] <= item.vec_x;
      vec_s1[1] <= item.vec_y;
      vec_s1[2] <= item.vec_z;
    end
    if (ctl.coef) begin
      vec_s2 <= vec_s1;
    end
  end

  qrv_coef u_coef (
    .clk    (clk),
    .ctl    (ctl),
    .quat_x (item.quat_x),
    .quat_y (item.quat_y),
    .quat_z (item.quat_z),
    .quat_w (item.quat_w),
    .coef   (coef)
  );

  for (genvar r = 0; r < 3; r++) begin : g_row
    qrv_row u_row (
      .clk  (clk),
      .ctl  (ctl),
      .coef (coef[r]),
      .vec  (vec_s2),
      .rot  (rot[r]),
      .clip (clip[r])
    );
  end

  assign item.ready     = ready[0];
  assign result.valid   = valid[STAGES-1];
  assign result.rot_x   = rot[0];
  assign result.rot_y   = rot[1];
  assign result.rot_z   = rot[2];
  assign result.clipped = clip[0] | clip[1] | clip[2];

endmodule

// ===== rtl/qrv_coef.sv =====
// ----------------------------------------------------------------------------
// qrv_coef
// Stages one and two: quadratic quaternion terms, then the nine rotation
// matrix coefficients.
// ----------------------------------------------------------------------------
module qrv_coef import qrv_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  quat_t     quat_x,
  input  quat_t     quat_y,
  input  quat_t     quat_z,
  input  quat_t     quat_w,
  output coef_t     coef [0:2][0:2]
);

  logic signed [PROD_W-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  coef_t coef_next [0:2][0:2];

  always_ff @(posedge clk) begin
    if (ctl.prod) begin
      ww <= quat_w * quat_w;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      xy <= quat_x * quat_y;
      xz <= quat_x * quat_z;
      yz <= quat_y * quat_z;
      wx <= quat_w * quat_x;
      wy <= quat_w * quat_y;
      wz <= quat_w * quat_z;
    end
  end

  always_comb begin
    coef_next[0][0] = COEF_W'(ww) + COEF_W'(xx) - COEF_W'(yy) - COEF_W'(zz);
    coef_next[1][1] = COEF_W'(ww) - COEF_W'(xx) + COEF_W'(yy) - COEF_W'(zz);
    coef_next[2][2] = COEF_W'(ww) - COEF_W'(xx) - COEF_W'(yy) + COEF_W'(zz);
    // Off-diagonal terms are doubled; the difference fits one bit below the top.
    coef_next[0][1] = (COEF_W'(xy) - COEF_W'(wz)) <<< 1;
    coef_next[0][2] = (COEF_W'(xz) + COEF_W'(wy)) <<< 1;
    coef_next[1][0] = (COEF_W'(xy) + COEF_W'(wz)) <<< 1;
    coef_next[1][2] = (COEF_W'(yz) - COEF_W'(wx)) <<< 1;
    coef_next[2][0] = (COEF_W'(xz) - COEF_W'(wy)) <<< 1;
    coef_next[2][1] = (COEF_W'(yz) + COEF_W'(wx)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (ctl.coef) begin
      coef <= coef_next;
    end
  end

endmodule

// ===== rtl/qrv_row.sv =====
// ----------------------------------------------------------------------------
// qrv_row
// Stages three to five for one output component: split multiplies, exact
// accumulation, then round half up and saturate to Q16.16.
// ----------------------------------------------------------------------------
module qrv_row import qrv_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  coef_t     coef [0:2],
  input  vec_t      vec  [0:2],
  output vec_t      rot,
  output logic      clip
);

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_DROP - 1);

  logic signed [HALF_W-1:0] vh [0:2];
  logic signed [HALF_W:0]   vl [0:2];
  logic signed [PH_W-1:0]   ph [0:2];
  logic signed [PL_W-1:0]   pl [0:2];
  logic signed [HI_W-1:0]   hi;
  logic signed [LO_W-1:0]   lo;
  logic signed [SUM_W-1:0]  total;
  logic signed [RES_W-1:0]  res;
  logic                     over;
  vec_t                     rot_next;

  // The vector is split into a signed high half and an unsigned low half.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vh[i] = vec[i][VEC_W-1:HALF_W];
      vl[i] = {1'b0, vec[i][HALF_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      for (int i = 0; i < 3; i++) begin
        ph[i] <= coef[i] * vh[i];
        pl[i] <= coef[i] * vl[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      hi <= HI_W'(ph[0]) + HI_W'(ph[1]) + HI_W'(ph[2]);
      lo <= LO_W'(pl[0]) + LO_W'(pl[1]) + LO_W'(pl[2]);
    end
  end

  always_comb begin
    total = (SUM_W'(hi) <<< HALF_W) + SUM_W'(lo) + ROUND_HALF;
    res   = total[SUM_W-1:FRAC_DROP];
    // The value fits when every bit above the 32-bit sign matches it.
    over  = (res[RES_W-1:VEC_W-1] != {(RES_W-VEC_W+1){1'b0}}) &&
            (res[RES_W-1:VEC_W-1] != {(RES_W-VEC_W+1){1'b1}});
    if (!over) begin
      rot_next = res[VEC_W-1:0];
    end else if (res[RES_W-1]) begin
      rot_next = {1'b1, {(VEC_W-1){1'b0}}};
    end else begin
      rot_next = {1'b0, {(VEC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      rot  <= rot_next;
      clip <= over;
    end
  end

endmodule
